[hdl/asc128_pkg.sv]
// shared types, constants and permutation functions for the ascon-128 encryption core
// no dependencies; used by every module in hdl
package asc128_pkg;

  localparam int INIT_ROUNDS = 12;
  localparam int DATA_ROUNDS = 6;

  // round index range of the shared round unit
  localparam logic [3:0] RC_FIRST_INIT = 4'd0;
  localparam logic [3:0] RC_FIRST_DATA = 4'(INIT_ROUNDS - DATA_ROUNDS);
  localparam logic [3:0] RC_LAST       = 4'(INIT_ROUNDS - 1);

  localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
  localparam logic [63:0] PAD_FULL = 64'h8000000000000000;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  // input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_AD    = 2'd1;
  localparam logic [1:0] CMD_PT    = 2'd2;

  // result kinds
  localparam logic KIND_CT  = 1'b0;
  localparam logic KIND_TAG = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef enum logic [1:0] {
    OP_START,
    OP_AD,
    OP_PT
  } op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [3:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [3:0]  out_bytes;
    logic        end_of_run;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    op_e         op;
    logic [63:0] nonce_high;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } job_t;

  typedef logic [4:0][63:0] state_t;

  function automatic logic [63:0] rotr(logic [63:0] v, int unsigned r);
    return (v >> r) | (v << (64 - r));
  endfunction

  // leading n bytes, n in 0..8
  function automatic logic [63:0] lead_mask(logic [3:0] n);
    logic [63:0] m;
    if (n >= FULL_BYTES) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} >> {n[2:0], 3'b000});
    end
    return m;
  endfunction

  // 10* pad bit right after the leading n bytes, n in 0..7
  function automatic logic [63:0] pad_bit(logic [2:0] n);
    return PAD_FULL >> {n, 3'b000};
  endfunction

  // one permutation round, idx selects the round constant
  function automatic state_t asc_round(state_t s, logic [3:0] idx);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    state_t r;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {56'd0, ~idx, idx};
    x3 = s[3];
    x4 = s[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    t0 = ~x0 & x1;
    t1 = ~x1 & x2;
    t2 = ~x2 & x3;
    t3 = ~x3 & x4;
    t4 = ~x4 & x0;
    x0 = x0 ^ t1;
    x1 = x1 ^ t2;
    x2 = x2 ^ t3;
    x3 = x3 ^ t4;
    x4 = x4 ^ t0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    r[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
    r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    r[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    return r;
  endfunction

endpackage

[hdl/ascon128_aead_encrypt_core.sv]
// top level of the ascon-128 authenticated encryption core
// depends on asc128_pkg, asc128_front, asc128_queue and asc128_back
//
// usage:
//   input channel (in_valid_i/in_ready_o, in_item_i) takes one beat per command:
//   start with the 128-bit nonce, associated-data words, plaintext words.
//   output channel (out_valid_o/out_ready_i, out_item_o) returns ciphertext
//   words and, after the last plaintext word, the 128-bit tag.
//   key registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// timing:
//   a two-entry queue decouples the front from the sequencer, so beats are
//   taken while the back end works. one permutation round per cycle on the
//   single round unit sets the pace unless the tag waits for the output
//   register: start runs the initialization permutation, each data word an
//   absorb plus six rounds, a full last associated data word one more padding
//   block. a ciphertext beat passes the queue, then the output register; the
//   tag follows the finalization permutation, after six more rounds for a full
//   last plaintext word. closing open associated data adds a padding block.
// reset:
//   clears the keys, the cipher state, the phase and the queue; no clearing pass.
// stall:
//   a result waits in the output register; the back end holds when it needs
//   that register, the queue fills and in_ready_o drops.
module ascon128_aead_encrypt_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // key configuration
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [63:0]           cfg_data_i,
  // command beats
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  asc128_pkg::in_item_t  in_item_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output asc128_pkg::out_item_t out_item_o
);

  logic [63:0]      key_high_q;
  logic [63:0]      key_low_q;
  logic             q_full;
  logic             push;
  asc128_pkg::job_t push_job;
  logic             job_valid;
  asc128_pkg::job_t job;
  logic             pop;

  // key registers, one write per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asc128_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        asc128_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify incoming beats
  asc128_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // decoupling queue
  asc128_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .item_o  (job)
  );

  // round sequencer and result register
  asc128_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_high_i  (key_high_q),
    .key_low_i   (key_low_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/asc128_front.sv]
// front end: accepts input beats, classifies the command and normalizes the byte count
// depends on asc128_pkg; feeds asc128_queue
module asc128_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  asc128_pkg::in_item_t in_item_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output asc128_pkg::job_t     job_o
);

  logic       known;
  logic [3:0] nsat;

  assign in_ready_o = !q_full_i;

  // short count only on the last word, anything above 8 saturates
  assign nsat = (in_item_i.byte_count > asc128_pkg::FULL_BYTES) ? asc128_pkg::FULL_BYTES
                                                                 : in_item_i.byte_count;

  always_comb begin
    known            = 1'b1;
    job_o.op         = asc128_pkg::OP_START;
    job_o.nonce_high = in_item_i.data_high;
    job_o.word       = in_item_i.data_low;
    job_o.nbytes     = in_item_i.last ? nsat : asc128_pkg::FULL_BYTES;
    job_o.last       = in_item_i.last;
    case (in_item_i.cmd)
      asc128_pkg::CMD_START: job_o.op = asc128_pkg::OP_START;
      asc128_pkg::CMD_AD:    job_o.op = asc128_pkg::OP_AD;
      asc128_pkg::CMD_PT:    job_o.op = asc128_pkg::OP_PT;
      default:               known = 1'b0;
    endcase
  end

  // unused command is taken and dropped
  assign push_o = in_valid_i && !q_full_i && known;

endmodule

[hdl/asc128_queue.sv]
// two-entry job queue between front and back
// depends on asc128_pkg
module asc128_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  asc128_pkg::job_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output asc128_pkg::job_t item_o
);

  asc128_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/asc128_back.sv]
// back end: sequencer around one shared permutation round, phase tracking, result register
// depends on asc128_pkg; takes jobs from asc128_queue
module asc128_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           key_high_i,
  input  logic [63:0]           key_low_i,
  input  logic                  job_valid_i,
  input  asc128_pkg::job_t      job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output asc128_pkg::out_item_t out_item_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PERM = 1'b1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_AD    = 2'd2;
  localparam logic [1:0] PH_PT    = 2'd3;

  localparam logic [2:0] POST_NONE   = 3'd0;
  localparam logic [2:0] POST_INIT   = 3'd1;
  localparam logic [2:0] POST_ADPAD  = 3'd2;
  localparam logic [2:0] POST_ADEND  = 3'd3;
  localparam logic [2:0] POST_PTFULL = 3'd4;
  localparam logic [2:0] POST_TAG    = 3'd5;

  logic                  st_q, st_d;
  logic [1:0]            phase_q, phase_d;
  logic [2:0]            post_q, post_d;
  logic [3:0]            rc_q, rc_d;
  asc128_pkg::state_t    x_q, x_d;
  asc128_pkg::state_t    rnd;
  logic                  out_valid_q, out_valid_d;
  asc128_pkg::out_item_t out_q, out_d;
  logic                  out_free;
  logic [63:0]           mask;
  logic [63:0]           xa0;
  logic                  short_word;

  assign out_free   = !out_valid_q || out_ready_i;
  assign rnd        = asc128_pkg::asc_round(x_q, rc_q);
  assign mask       = asc128_pkg::lead_mask(job_i.nbytes);
  assign xa0        = x_q[0] ^ (job_i.word & mask);
  assign short_word = (job_i.nbytes < asc128_pkg::FULL_BYTES);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    post_d      = post_q;
    rc_d        = rc_q;
    x_d         = x_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            asc128_pkg::OP_START: begin
              pop_o   = 1'b1;
              x_d[0]  = asc128_pkg::ASCON_IV;
              x_d[1]  = key_high_i;
              x_d[2]  = key_low_i;
              x_d[3]  = job_i.nonce_high;
              x_d[4]  = job_i.word;
              rc_d    = asc128_pkg::RC_FIRST_INIT;
              post_d  = POST_INIT;
              st_d    = ST_PERM;
            end
            asc128_pkg::OP_AD: begin
              pop_o = 1'b1;
              if (phase_q == PH_START || phase_q == PH_AD) begin
                x_d[0] = xa0 ^ (short_word ? asc128_pkg::pad_bit(job_i.nbytes[2:0]) : '0);
                rc_d    = asc128_pkg::RC_FIRST_DATA;
                phase_d = PH_AD;
                st_d    = ST_PERM;
                if (!job_i.last) begin
                  post_d = POST_NONE;
                end else if (short_word) begin
                  post_d = POST_ADEND;
                end else begin
                  post_d = POST_ADPAD;
                end
              end
            end
            asc128_pkg::OP_PT: begin
              if (phase_q == PH_IDLE) begin
                pop_o = 1'b1;
              end else if (phase_q == PH_AD) begin
                // close open associated data before the word is taken
                x_d[0] = x_q[0] ^ asc128_pkg::PAD_FULL;
                rc_d   = asc128_pkg::RC_FIRST_DATA;
                post_d = POST_ADEND;
                st_d   = ST_PERM;
              end else if (out_free) begin
                pop_o       = 1'b1;
                phase_d     = PH_PT;
                x_d[4]      = x_q[4] ^ {63'd0, (phase_q == PH_START)};
                out_valid_d = 1'b1;
                out_d.kind       = asc128_pkg::KIND_CT;
                out_d.out_high   = '0;
                out_d.out_low    = xa0 & mask;
                out_d.out_bytes  = job_i.nbytes;
                out_d.end_of_run = !job_i.last;
                st_d   = ST_PERM;
                x_d[0] = xa0;
                if (!job_i.last) begin
                  rc_d   = asc128_pkg::RC_FIRST_DATA;
                  post_d = POST_NONE;
                end else if (short_word) begin
                  x_d[0] = xa0 ^ asc128_pkg::pad_bit(job_i.nbytes[2:0]);
                  x_d[1] = x_q[1] ^ key_high_i;
                  x_d[2] = x_q[2] ^ key_low_i;
                  rc_d   = asc128_pkg::RC_FIRST_INIT;
                  post_d = POST_TAG;
                end else begin
                  rc_d   = asc128_pkg::RC_FIRST_DATA;
                  post_d = POST_PTFULL;
                end
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_PERM: begin
        if (rc_q != asc128_pkg::RC_LAST) begin
          x_d  = rnd;
          rc_d = rc_q + 4'd1;
        end else begin
          case (post_q)
            POST_INIT: begin
              x_d     = rnd;
              x_d[3]  = rnd[3] ^ key_high_i;
              x_d[4]  = rnd[4] ^ key_low_i;
              phase_d = PH_START;
              st_d    = ST_IDLE;
            end
            POST_ADPAD: begin
              x_d    = rnd;
              x_d[0] = rnd[0] ^ asc128_pkg::PAD_FULL;
              rc_d   = asc128_pkg::RC_FIRST_DATA;
              post_d = POST_ADEND;
            end
            POST_ADEND: begin
              x_d     = rnd;
              x_d[4]  = rnd[4] ^ 64'd1;
              phase_d = PH_PT;
              st_d    = ST_IDLE;
            end
            POST_PTFULL: begin
              x_d    = rnd;
              x_d[0] = rnd[0] ^ asc128_pkg::PAD_FULL;
              x_d[1] = rnd[1] ^ key_high_i;
              x_d[2] = rnd[2] ^ key_low_i;
              rc_d   = asc128_pkg::RC_FIRST_INIT;
              post_d = POST_TAG;
            end
            POST_TAG: begin
              // hold the last round until the result register frees up
              if (out_free) begin
                x_d         = rnd;
                out_valid_d = 1'b1;
                out_d.kind       = asc128_pkg::KIND_TAG;
                out_d.out_high   = rnd[3] ^ key_high_i;
                out_d.out_low    = rnd[4] ^ key_low_i;
                out_d.out_bytes  = asc128_pkg::FULL_BYTES;
                out_d.end_of_run = 1'b1;
                phase_d = PH_IDLE;
                st_d    = ST_IDLE;
              end
            end
            default: begin
              x_d  = rnd;
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_IDLE;
      post_q      <= POST_NONE;
      rc_q        <= asc128_pkg::RC_FIRST_INIT;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      post_q      <= post_d;
      rc_q        <= rc_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

[tb/ascon128_aead_encrypt_core_tb.sv]
// self-checking testbench for the ascon-128 authenticated encryption core
// depends on asc128_pkg and ascon128_aead_encrypt_core; predicts ciphertext and tags
// on its own and checks every result beat against them
module ascon128_aead_encrypt_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asc128_pkg::*;

  // command code that the core must drop
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // idle time after the last result before touching the keys or ending:
  // two queued beats plus the one in the sequencer, none of them producing a result
  localparam int unsigned QUIET_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned SWEEP_BEATS  = 150;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FRESH,
    PH_AD,
    PH_PT
  } run_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;

  // mirror of the cipher: sponge words, key, run phase and ad closure
  logic [4:0][63:0] sponge;
  logic [63:0]      key_hi;
  logic [63:0]      key_lo;
  run_phase_e       run_phase;
  bit               ad_sealed;

  // ciphertext and tag beats predicted but not yet seen, oldest first
  out_item_t ct_tag_queue[$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned beats_sent   = 0;
  int unsigned runs_started = 0;
  int unsigned key_settings = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_cycles  = 0;
  bit          quiet_mode   = 1'b0;

  always #1 clk_i = ~clk_i;

  ascon128_aead_encrypt_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // cipher mirror
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] ror64(logic [63:0] v, int unsigned r);
    logic [127:0] w;
    w = {v, v} >> r;
    return w[63:0];
  endfunction

  // leading n bytes of a big-endian word, n in 0..8
  function automatic logic [63:0] lead_bytes(int unsigned n);
    if (n == 0) return '0;
    return {64{1'b1}} << (64 - 8 * n);
  endfunction

  // 10* pad bit right behind the leading n bytes, n in 0..7
  function automatic logic [63:0] pad_after(int unsigned n);
    return 64'h80 << (56 - 8 * n);
  endfunction

  // last `rounds` rounds of the 12-round schedule
  task automatic ascon_permute(input int rounds);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    int unsigned rc;
    x0 = sponge[0];
    x1 = sponge[1];
    x2 = sponge[2];
    x3 = sponge[3];
    x4 = sponge[4];
    for (int i = INIT_ROUNDS - rounds; i < INIT_ROUNDS; i++) begin
      rc = 240 - 15 * i;
      x2 ^= 64'(rc);
      // s-box layer, bitsliced
      x0 ^= x4;
      x4 ^= x3;
      x2 ^= x1;
      t0 = x1 & ~x0;
      t1 = x2 & ~x1;
      t2 = x3 & ~x2;
      t3 = x4 & ~x3;
      t4 = x0 & ~x4;
      x0 ^= t1;
      x1 ^= t2;
      x2 ^= t3;
      x3 ^= t4;
      x4 ^= t0;
      x1 ^= x0;
      x0 ^= x4;
      x3 ^= x2;
      x2 = ~x2;
      // linear diffusion
      x0 ^= ror64(x0, 19) ^ ror64(x0, 28);
      x1 ^= ror64(x1, 61) ^ ror64(x1, 39);
      x2 ^= ror64(x2, 1) ^ ror64(x2, 6);
      x3 ^= ror64(x3, 10) ^ ror64(x3, 17);
      x4 ^= ror64(x4, 7) ^ ror64(x4, 41);
    end
    sponge[0] = x0;
    sponge[1] = x1;
    sponge[2] = x2;
    sponge[3] = x3;
    sponge[4] = x4;
  endtask

  // advance the mirror by one accepted beat and queue the results it causes
  task automatic ascon_encrypt_step(input in_item_t it);
    int unsigned n;
    out_item_t   r;
    n = (it.byte_count > FULL_BYTES) ? 8 : it.byte_count;
    // short words only count as short when marked last
    if (!it.last) n = 8;
    r = '0;
    case (it.cmd)
      CMD_START: begin
        sponge[0] = ASCON_IV;
        sponge[1] = key_hi;
        sponge[2] = key_lo;
        sponge[3] = it.data_high;
        sponge[4] = it.data_low;
        ascon_permute(INIT_ROUNDS);
        sponge[3] ^= key_hi;
        sponge[4] ^= key_lo;
        run_phase = PH_FRESH;
        ad_sealed = 1'b0;
      end
      CMD_AD: begin
        // dropped before a start and once ad is closed
        if ((run_phase == PH_FRESH || run_phase == PH_AD) && !ad_sealed) begin
          sponge[0] ^= it.data_low & lead_bytes(n);
          if (n < 8) sponge[0] ^= pad_after(n);
          ascon_permute(DATA_ROUNDS);
          run_phase = PH_AD;
          if (it.last) begin
            // full last word: padding goes in a block of its own
            if (n == 8) begin
              sponge[0] ^= pad_after(0);
              ascon_permute(DATA_ROUNDS);
            end
            sponge[4] ^= 64'd1;
            ad_sealed = 1'b1;
            run_phase = PH_PT;
          end
        end
      end
      CMD_PT: begin
        if (run_phase != PH_IDLE) begin
          // plaintext closes any ad still open, padding only if words went in
          if (!ad_sealed || run_phase != PH_PT) begin
            if (run_phase == PH_AD) begin
              sponge[0] ^= pad_after(0);
              ascon_permute(DATA_ROUNDS);
            end
            sponge[4] ^= 64'd1;
            ad_sealed = 1'b1;
            run_phase = PH_PT;
          end
          sponge[0] ^= it.data_low & lead_bytes(n);
          r.kind     = KIND_CT;
          r.out_high = '0;
          r.out_low  = sponge[0] & lead_bytes(n);
          if (!it.last) begin
            ascon_permute(DATA_ROUNDS);
            r.out_bytes  = FULL_BYTES;
            r.end_of_run = 1'b1;
            ct_tag_queue.push_back(r);
          end else begin
            if (n < 8) begin
              sponge[0] ^= pad_after(n);
            end else begin
              ascon_permute(DATA_ROUNDS);
              sponge[0] ^= pad_after(0);
            end
            r.out_bytes  = 4'(n);
            r.end_of_run = 1'b0;
            ct_tag_queue.push_back(r);
            // finalization
            sponge[1] ^= key_hi;
            sponge[2] ^= key_lo;
            ascon_permute(INIT_ROUNDS);
            r.kind       = KIND_TAG;
            r.out_high   = sponge[3] ^ key_hi;
            r.out_low    = sponge[4] ^ key_lo;
            r.out_bytes  = FULL_BYTES;
            r.end_of_run = 1'b1;
            ct_tag_queue.push_back(r);
            run_phase = PH_IDLE;
            ad_sealed = 1'b0;
          end
        end
      end
      default: begin
        // unused command code: nothing happens
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_beat(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                                         logic [3:0] nb, logic lst);
    in_item_t b;
    b.cmd        = cmd;
    b.data_high  = hi;
    b.data_low   = lo;
    b.byte_count = nb;
    b.last       = lst;
    return b;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // byte count of a data word: legal most of the time, any 4-bit value now and then
  function automatic logic [3:0] word_count(bit is_last);
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return is_last ? 4'($urandom_range(0, 8)) : FULL_BYTES;
  endfunction

  // offer one beat after a random gap, predict once it is taken
  task automatic push_beat(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    ascon_encrypt_step(it);
    beats_sent++;
    if (it.cmd == CMD_START) runs_started++;
  endtask

  // stop offering and wait for every predicted beat to come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ct_tag_queue.size() != 0) @(posedge clk_i);
  endtask

  // drained, plus time for beats that produce nothing to work through
  task automatic settle();
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // both key halves on back-to-back cycles; only called when settled
  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_KEY_HIGH;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_KEY_LOW;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_hi = hi;
    key_lo = lo;
    key_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // right after reset nothing is started, so data and the unused code are dropped
  task automatic test_ignored_before_start();
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), FULL_BYTES, 1'b1));
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd4, 1'b1));
    push_beat(make_beat(CMD_UNUSED, rnd64(), rnd64(), 4'd9, 1'b0));
  endtask

  // a full run with the all-zero key left by reset
  task automatic test_reset_key();
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'd0, 1'b0));
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), FULL_BYTES, 1'b1));
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd5, 1'b1));
  endtask

  task automatic test_directed_cases();
    settle();
    load_key(rnd64(), rnd64());
    // all-ones nonce, no ad, empty plaintext: zero-byte word then the tag
    push_beat(make_beat(CMD_START, '1, '1, 4'd0, 1'b0));
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd0, 1'b1));
    // all-zero nonce
    push_beat(make_beat(CMD_START, '0, '0, 4'd15, 1'b1));
    push_beat(make_beat(CMD_AD, '0, '1, FULL_BYTES, 1'b0));
    // short word without last counts as full
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd3, 1'b0));
    // full last ad word pulls in an extra padding block
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), FULL_BYTES, 1'b1));
    // ad after it was closed is dropped
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd2, 1'b1));
    // count above 8 saturates
    push_beat(make_beat(CMD_PT, '1, '1, 4'd15, 1'b0));
    // full last plaintext word
    push_beat(make_beat(CMD_PT, rnd64(), '0, FULL_BYTES, 1'b1));
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), FULL_BYTES, 1'b0));
    // empty last ad word
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd0, 1'b1));
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd7, 1'b1));
    // restart while ad is still open
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'd0, 1'b0));
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd5, 1'b0));
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'd0, 1'b0));
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd2, 1'b0));
    // plaintext closes the open ad; saturated last count
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd12, 1'b1));
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'd0, 1'b0));
    push_beat(make_beat(CMD_PT, rnd64(), '0, FULL_BYTES, 1'b0));
    // unused code in the middle of a run
    push_beat(make_beat(CMD_UNUSED, '1, '1, 4'd15, 1'b1));
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd1, 1'b1));
  endtask

  // receiver blocks long enough for the core to fill up, then the sender
  // waits mid-run for every result before finishing the message
  task automatic test_stall_and_drain();
    settle();
    quiet_mode  = 1'b1;
    hold_cycles = 300;
    push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'd0, 1'b0));
    push_beat(make_beat(CMD_AD, rnd64(), rnd64(), 4'd6, 1'b1));
    repeat (16) push_beat(make_beat(CMD_PT, rnd64(), rnd64(), FULL_BYTES, 1'b0));
    drain_results();
    quiet_mode = 1'b0;
    push_beat(make_beat(CMD_PT, rnd64(), rnd64(), 4'd4, 1'b1));
  endtask

  // random runs under a series of keys, extremes first
  task automatic test_key_sweep();
    logic [63:0] hi_set [6];
    logic [63:0] lo_set [6];
    int unsigned done_beats, n_ad, n_pt, n_words, cut;
    bit          open_ad;
    bit          is_last;
    hi_set = '{'1, '1, '0, '0, '0, '0};
    lo_set = '{'1, '0, '1, '0, '0, '0};
    for (int s = 3; s < 6; s++) begin
      hi_set[s] = rnd64();
      lo_set[s] = rnd64();
    end
    for (int s = 0; s < 6; s++) begin
      settle();
      load_key(hi_set[s], lo_set[s]);
      // one stretch runs with no idling on either side
      quiet_mode = (s == 2);
      done_beats = 0;
      while (done_beats < SWEEP_BEATS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any field value, any command
          push_beat(make_beat(2'($urandom_range(0, 3)), rnd64(), rnd64(),
                              4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end else begin
          n_ad    = $urandom_range(0, 3);
          n_pt    = $urandom_range(1, 4);
          n_words = n_ad + n_pt;
          // some runs leave ad open and let the plaintext close it
          open_ad = ($urandom_range(0, 3) == 0);
          // some runs break off early; the next start restarts
          cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, n_words) : n_words;
          push_beat(make_beat(CMD_START, rnd64(), rnd64(), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1))));
          done_beats++;
          for (int k = 0; k < cut; k++) begin
            if (k < n_ad) begin
              is_last = (k == n_ad - 1) && !open_ad;
              push_beat(make_beat(CMD_AD, rnd64(), rnd64(), word_count(is_last), is_last));
            end else begin
              // now and then the sender waits out every result mid-run
              if ($urandom_range(0, 29) == 0) drain_results();
              is_last = (k == n_words - 1);
              push_beat(make_beat(CMD_PT, rnd64(), rnd64(), word_count(is_last), is_last));
            end
            done_beats++;
          end
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready with random stalls; a requested hold is counted down here
  initial begin : result_sink
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // every result beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (ct_tag_queue.size() == 0) begin
        fail_count++;
        $error("result beat with nothing predicted: kind %0d out_low %h",
               out_item_o.kind, out_item_o.out_low);
      end else begin
        want = ct_tag_queue.pop_front();
        if (out_item_o.kind !== want.kind) begin
          fail_count++;
          $error("kind: expected %0d, got %0d", want.kind, out_item_o.kind);
        end
        if (out_item_o.out_high !== want.out_high) begin
          fail_count++;
          $error("out_high: expected %h, got %h", want.out_high, out_item_o.out_high);
        end
        if (out_item_o.out_low !== want.out_low) begin
          fail_count++;
          $error("out_low: expected %h, got %h", want.out_low, out_item_o.out_low);
        end
        if (out_item_o.out_bytes !== want.out_bytes) begin
          fail_count++;
          $error("out_bytes: expected %0d, got %0d", want.out_bytes, out_item_o.out_bytes);
        end
        if (out_item_o.end_of_run !== want.end_of_run) begin
          fail_count++;
          $error("end_of_run: expected %0d, got %0d", want.end_of_run, out_item_o.end_of_run);
        end
      end
    end
  end

  // hard stop if the core hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding",
             cycle_count, ct_tag_queue.size());
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_KEY_HIGH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    // mirror matches the core out of reset
    sponge    = '0;
    key_hi    = '0;
    key_lo    = '0;
    run_phase = PH_IDLE;
    ad_sealed = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_before_start();
    test_reset_key();
    test_directed_cases();
    test_stall_and_drain();
    test_key_sweep();

    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);

    $display("sent %0d command beats over %0d runs under %0d key settings plus the reset key",
             beats_sent, runs_started, key_settings);
    $display("checked %0d ciphertext and tag beats in %0d cycles, %0d field mismatches",
             results_seen, cycle_count, fail_count);
    if (fail_count == 0 && ct_tag_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
